@@ sv/xyzlab_pkg.sv @@
`default_nettype none
package xyzlab_pkg;

    // input and working widths
    localparam int VAL_W   = 17;
    localparam int RECIP_W = 31;
    localparam int PROD_W  = VAL_W + RECIP_W;
    localparam int ROOT_W  = 20;
    localparam int CUBE_W  = 3 * ROOT_W;
    localparam int OUT_W   = 18;
    localparam int WORK_FRAC = 16;

    // reciprocal white point in Q30, rounded to nearest
    localparam logic [63:0] RECIP_X_FULL =
        ((64'd1 << 30) * 64'd1000000 + 64'd482147) / 64'd964294;
    localparam logic [63:0] RECIP_Z_FULL =
        ((64'd1 << 30) * 64'd1000000 + 64'd412552) / 64'd825104;
    localparam logic [RECIP_W-1:0] RECIP_X = RECIP_X_FULL[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'(64'd1 << 30);
    localparam logic [RECIP_W-1:0] RECIP_Z = RECIP_Z_FULL[RECIP_W-1:0];

    // knee of f(t): t above this takes the cube root
    localparam logic [63:0] T_KNEE = (64'd216 << 32) / 64'd24389;

    // linear segment: t below the knee fits in LIN_T_W bits
    localparam int LIN_T_W   = 26;
    localparam int LIN_P_W   = 41;
    localparam int LIN_S_W   = 42;
    localparam int LIN_Q_W   = 26;
    localparam int LIN_M_W   = 27;
    localparam int LIN_QM_W  = LIN_Q_W + LIN_M_W;
    localparam int LIN_SHIFT = 38;
    localparam int LIN_F_W   = LIN_QM_W - LIN_SHIFT;
    localparam logic [14:0] LIN_GAIN = 15'd24389;
    localparam logic [63:0] LIN_OFS_FULL = (64'd432 << 32) + (64'd3132 << 15);
    localparam logic [LIN_S_W-1:0] LIN_OFS = LIN_OFS_FULL[LIN_S_W-1:0];
    // ceil(2^38 / 3132), exact floor division for every quotient input here
    localparam logic [63:0] LIN_RECIP_FULL = ((64'd1 << 38) + 64'd3131) / 64'd3132;
    localparam logic [LIN_M_W-1:0] LIN_RECIP = LIN_RECIP_FULL[LIN_M_W-1:0];

    // pipeline depth of one channel lane
    localparam int PRE_STAGES = 4;
    localparam int LANE_LAT   = PRE_STAGES + ROOT_W;

    // state carried down the cube root chain
    typedef struct packed {
        logic [CUBE_W-1:0]  n;
        logic [ROOT_W-1:0]  r;
        logic [2*ROOT_W-1:0] r2;
        logic [CUBE_W-1:0]  r3;
        logic [LIN_F_W-1:0] f_lin;
        logic               is_cube;
    } cbrt_state_t;

endpackage
`default_nettype wire

@@ sv/xyzlab_cbrt_step.sv @@
`default_nettype none
module xyzlab_cbrt_step #(
    parameter int BIT = 19
) (
    input  wire logic                  aclk,
    input  wire logic                  ce,
    input  wire xyzlab_pkg::cbrt_state_t st_in,
    output      xyzlab_pkg::cbrt_state_t st_out
);

    xyzlab_pkg::cbrt_state_t st_reg, st_next;
    logic [63:0] r_w, r2_w, c2, c3;
    logic        take;

    // trial bit: expand (r + 2^b)^2 and ^3 with shifts and adds
    always_comb begin
        r_w  = 64'(st_in.r);
        r2_w = 64'(st_in.r2);
        c2 = r2_w + (r_w << (BIT + 1)) + (64'd1 << (2 * BIT));
        c3 = 64'(st_in.r3) + ((r2_w + (r2_w << 1)) << BIT)
           + ((r_w + (r_w << 1)) << (2 * BIT)) + (64'd1 << (3 * BIT));
        take = (c3 <= 64'(st_in.n));
        st_next = st_in;
        if (take) begin
            st_next.r  = st_in.r | (xyzlab_pkg::ROOT_W'(1) << BIT);
            st_next.r2 = c2[2*xyzlab_pkg::ROOT_W-1:0];
            st_next.r3 = c3[xyzlab_pkg::CUBE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule
`default_nettype wire

@@ sv/xyzlab_lane.sv @@
`default_nettype none
module xyzlab_lane #(
    parameter int                   IN_FRAC_BITS = 16,
    parameter logic [30:0]          RECIP        = 31'h40000000
) (
    input  wire logic                              aclk,
    input  wire logic                              ce,
    input  wire logic [xyzlab_pkg::VAL_W-1:0]      value,
    output      logic [xyzlab_pkg::ROOT_W-1:0]     f_out
);

    localparam int TQ_W = xyzlab_pkg::PROD_W - (IN_FRAC_BITS - 2);

    logic [xyzlab_pkg::PROD_W-1:0]  prod_reg;
    logic [TQ_W-1:0]                tq;
    logic [xyzlab_pkg::CUBE_W-1:0]  n_s2_reg, n_s3_reg, n_s4_reg;
    logic                           cube_s2_reg, cube_s3_reg, cube_s4_reg;
    logic [xyzlab_pkg::LIN_P_W-1:0] lin_s2_reg;
    logic [xyzlab_pkg::LIN_Q_W-1:0] q_s3_reg;
    logic [xyzlab_pkg::LIN_QM_W-1:0] qm_s4_reg;
    logic [xyzlab_pkg::LIN_S_W-1:0] lin_sum;
    xyzlab_pkg::cbrt_state_t        chain_seed;
    xyzlab_pkg::cbrt_state_t        chain [0:xyzlab_pkg::ROOT_W];

    // normalized t in Q32
    assign tq = prod_reg[xyzlab_pkg::PROD_W-1:IN_FRAC_BITS-2];
    assign lin_sum = xyzlab_pkg::LIN_S_W'(lin_s2_reg) + xyzlab_pkg::LIN_OFS;

    // scale, knee test and linear segment
    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg    <= xyzlab_pkg::PROD_W'(value) * xyzlab_pkg::PROD_W'(RECIP);
            n_s2_reg    <= xyzlab_pkg::CUBE_W'(tq) << xyzlab_pkg::WORK_FRAC;
            cube_s2_reg <= (64'(tq) > xyzlab_pkg::T_KNEE);
            lin_s2_reg  <= xyzlab_pkg::LIN_P_W'(tq[xyzlab_pkg::LIN_T_W-1:0])
                         * xyzlab_pkg::LIN_P_W'(xyzlab_pkg::LIN_GAIN);
            n_s3_reg    <= n_s2_reg;
            cube_s3_reg <= cube_s2_reg;
            q_s3_reg    <= lin_sum[xyzlab_pkg::LIN_S_W-1:16];
            n_s4_reg    <= n_s3_reg;
            cube_s4_reg <= cube_s3_reg;
            qm_s4_reg   <= xyzlab_pkg::LIN_QM_W'(q_s3_reg)
                         * xyzlab_pkg::LIN_QM_W'(xyzlab_pkg::LIN_RECIP);
        end
    end

    // seed of the cube root chain
    always_comb begin
        chain_seed.n       = n_s4_reg;
        chain_seed.r       = '0;
        chain_seed.r2      = '0;
        chain_seed.r3      = '0;
        chain_seed.f_lin   = qm_s4_reg[xyzlab_pkg::LIN_QM_W-1:xyzlab_pkg::LIN_SHIFT];
        chain_seed.is_cube = cube_s4_reg;
    end

    assign chain[0] = chain_seed;

    // one root bit per stage, msb first
    for (genvar i = 0; i < xyzlab_pkg::ROOT_W; i++) begin : g_root
        xyzlab_cbrt_step #(
            .BIT (xyzlab_pkg::ROOT_W - 1 - i)
        ) u_step (
            .aclk   (aclk),
            .ce     (ce),
            .st_in  (chain[i]),
            .st_out (chain[i+1])
        );
    end

    assign f_out = chain[xyzlab_pkg::ROOT_W].is_cube ? chain[xyzlab_pkg::ROOT_W].r
                 : xyzlab_pkg::ROOT_W'(chain[xyzlab_pkg::ROOT_W].f_lin);

endmodule
`default_nettype wire

@@ sv/xyz_to_lab_d50_unit.sv @@
// CIE XYZ to CIELAB (D50 white) converter for pixel streams.
// Input beats on s_tdata carry X, Y and Z, unsigned with IN_FRAC_BITS
// fraction bits. Output beats on m_tdata carry L*, a* and b*, signed,
// in OUT_FRAC_BITS fraction bits, saturated to 18 bits.
// Throughput: one beat per cycle while the receiver keeps m_tready high.
// Pipeline: the scaling, knee test and linear segment registers,
// then twenty cube root stages (one result bit each), then a register
// forming L*, a*, b* and a register of rounding and saturation, which
// is the output register.
// The whole pipeline advances together; s_tready is high whenever the
// output register is empty or being taken. When the receiver holds
// m_tready low with a beat pending, every stage freezes and nothing is
// lost or repeated. Synchronous reset clears all valid bits; the data
// path holds no reset.
`default_nettype none
module xyz_to_lab_d50_unit #(
    parameter int IN_FRAC_BITS  = 16,
    parameter int OUT_FRAC_BITS = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // x_value [16:0], y_value [33:17], z_value [50:34], zero [55:51]
    input  wire logic [55:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // lightness [17:0], red_green [35:18], yellow_blue [53:36], zero [55:54]
    output      logic [55:0] m_tdata
);

    localparam int SH = xyzlab_pkg::WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);
    localparam logic signed [31:0] OUT_MAX = 32'sd131071;
    localparam logic signed [31:0] OUT_MIN = -32'sd131072;

    logic                                ce;
    logic [xyzlab_pkg::LANE_LAT-1:0]     vld_pipe_reg, vld_pipe_next;
    logic [xyzlab_pkg::ROOT_W-1:0]       fx, fy, fz;
    logic signed [31:0]                  fx_s, fy_s, fz_s;
    logic signed [31:0]                  l_raw_reg, a_raw_reg, b_raw_reg;
    logic                                raw_vld_reg, raw_vld_next;
    logic                                out_vld_reg, out_vld_next;
    logic [xyzlab_pkg::OUT_W-1:0]        l_reg, a_reg, b_reg;

    function automatic logic [xyzlab_pkg::OUT_W-1:0] round_sat(
        input logic signed [31:0] v
    );
        logic signed [31:0] q;
        q = (v + HALF) >>> SH;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
        end
        return q[xyzlab_pkg::OUT_W-1:0];
    endfunction

    // whole pipeline moves when the output register can take a beat
    assign ce       = m_tready || !out_vld_reg;
    assign s_tready = ce;

    // one lane per channel
    xyzlab_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .RECIP(xyzlab_pkg::RECIP_X)) u_lane_x (
        .aclk(aclk), .ce(ce), .value(s_tdata[16:0]), .f_out(fx)
    );
    xyzlab_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .RECIP(xyzlab_pkg::RECIP_Y)) u_lane_y (
        .aclk(aclk), .ce(ce), .value(s_tdata[33:17]), .f_out(fy)
    );
    xyzlab_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .RECIP(xyzlab_pkg::RECIP_Z)) u_lane_z (
        .aclk(aclk), .ce(ce), .value(s_tdata[50:34]), .f_out(fz)
    );

    // valid bits alongside the lanes
    always_comb begin
        vld_pipe_next = vld_pipe_reg;
        raw_vld_next  = raw_vld_reg;
        out_vld_next  = out_vld_reg;
        if (ce) begin
            vld_pipe_next = {vld_pipe_reg[xyzlab_pkg::LANE_LAT-2:0], s_tvalid};
            raw_vld_next  = vld_pipe_reg[xyzlab_pkg::LANE_LAT-1];
            out_vld_next  = raw_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_pipe_reg <= '0;
            raw_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            vld_pipe_reg <= vld_pipe_next;
            raw_vld_reg  <= raw_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign fx_s = 32'(fx);
    assign fy_s = 32'(fy);
    assign fz_s = 32'(fz);

    // L*, a*, b* in Q16, then round and saturate
    always_ff @(posedge aclk) begin
        if (ce) begin
            l_raw_reg <= fy_s * 32'sd116 - (32'sd16 <<< xyzlab_pkg::WORK_FRAC);
            a_raw_reg <= (fx_s - fy_s) * 32'sd500;
            b_raw_reg <= (fy_s - fz_s) * 32'sd200;
            l_reg     <= round_sat(l_raw_reg);
            a_reg     <= round_sat(a_raw_reg);
            b_reg     <= round_sat(b_raw_reg);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, b_reg, a_reg, l_reg};

    // an accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_pipe_reg[0])
        else $error("accepted beat missing from first stage");

    // a stalled output freezes every stage
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(vld_pipe_reg) && $stable(raw_vld_reg)))
        else $error("pipeline moved during output stall");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) == 1'b0) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
